### rtl/xxtea_pkg.sv
// Package for the XXTEA block cipher core: request and result structs,
// schedule constants and the word mix function. No dependencies.
`default_nettype none

package xxtea_pkg;

	localparam int unsigned ROUND_COUNT  = 19;
	localparam int unsigned WORD_COUNT   = 4;
	localparam int unsigned STAGE_COUNT  = ROUND_COUNT * WORD_COUNT;
	localparam logic [31:0] CIPHER_DELTA = 32'h9E37_79B9;

	localparam int unsigned ADDR_WIDTH = 4;

	// Register byte addresses on the configuration port
	localparam logic [ADDR_WIDTH-1:0] REG_KEY_WORD_0 = 4'h0;
	localparam logic [ADDR_WIDTH-1:0] REG_KEY_WORD_1 = 4'h4;
	localparam logic [ADDR_WIDTH-1:0] REG_KEY_WORD_2 = 4'h8;
	localparam logic [ADDR_WIDTH-1:0] REG_KEY_WORD_3 = 4'hC;

	localparam logic ACTION_ENCRYPT = 1'b0;
	localparam logic ACTION_DECRYPT = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] data_word_0;
		logic [31:0] data_word_1;
		logic [31:0] data_word_2;
		logic [31:0] data_word_3;
	} xxtea_in_t;

	typedef struct packed {
		logic [31:0] result_word_0;
		logic [31:0] result_word_1;
		logic [31:0] result_word_2;
		logic [31:0] result_word_3;
	} xxtea_out_t;

	typedef logic [WORD_COUNT-1:0][31:0] word_vec_t;

	// One block in flight
	typedef struct packed {
		logic      action;
		word_vec_t word;
	} stage_t;

	// Running sum after n additions of the delta, modulo 2^32
	function automatic logic [31:0] round_sum(input int unsigned n);
		logic [63:0] prod;
		prod = 64'(n) * 64'(CIPHER_DELTA);
		return prod[31:0];
	endfunction

	// XXTEA mix term of one word update
	function automatic logic [31:0] mix_term(input logic [31:0] z, input logic [31:0] y,
			input logic [31:0] sum, input logic [31:0] kw);
		logic [31:0] a;
		logic [31:0] b;
		a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
		b = (sum ^ y) + (kw ^ z);
		return a ^ b;
	endfunction

endpackage

`default_nettype wire

### rtl/xxtea_block_cipher_core.sv
// XXTEA block cipher core: 76-stage pipeline, one word mix per stage,
// with key registers on an APB-style port. Depends on xxtea_pkg.
`default_nettype none

//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  request  | blk_valid / blk_ready  | blk_data  (xxtea_in_t)
//  result   | res_valid / res_ready  | res_data  (xxtea_out_t)
//  config   | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
//  One request enters per cycle while blk_ready is high. The first mix stage loads at
//  the accepting edge; the block then moves through the other 75 mix stages and into
//  the output register. The 76 mix stages cover the 19 rounds of four word updates.
//  A stalled result holds nothing until a block waits in the last stage; bubbles keep
//  moving until then, and after that the whole pipe holds together.
//  arst_n clears the key registers and all valid bits at once.

module xxtea_block_cipher_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                blk_valid,
	output logic                                     blk_ready,
	input  wire xxtea_pkg::xxtea_in_t                blk_data,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output xxtea_pkg::xxtea_out_t                    res_data,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [xxtea_pkg::ADDR_WIDTH-1:0]    paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);
	import xxtea_pkg::*;

	localparam int unsigned LAST = STAGE_COUNT - 1;

	logic [WORD_COUNT-1:0][31:0] key_q;
	logic [1:0]                  reg_sel;
	logic                        adv;
	logic                        res_valid_q;
	xxtea_out_t                  res_q;
	stage_t                      pipe_s  [STAGE_COUNT];
	logic                        vld_s   [STAGE_COUNT];
	stage_t                      stage_in[STAGE_COUNT];

	// Configuration port: word-aligned key registers
	assign reg_sel = paddr[3:2];
	assign pready  = 1'b1;
	assign prdata  = key_q[reg_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite) begin
			key_q[reg_sel] <= pwdata;
		end
	end

	// Advance the pipe unless a finished block sits in the last stage and cannot leave
	assign adv       = !vld_s[LAST] || !res_valid_q || res_ready;
	assign blk_ready = adv;

	// Feed the first stage straight from the request
	assign stage_in[0].action  = blk_data.action;
	assign stage_in[0].word[0] = blk_data.data_word_0;
	assign stage_in[0].word[1] = blk_data.data_word_1;
	assign stage_in[0].word[2] = blk_data.data_word_2;
	assign stage_in[0].word[3] = blk_data.data_word_3;

	for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_mix
		localparam int unsigned RND   = k / WORD_COUNT;
		localparam logic [31:0] SUM_E = round_sum(RND + 1);
		localparam logic [31:0] SUM_D = round_sum(ROUND_COUNT - RND);
		// Encrypt walks words 0..3, decrypt walks 3..0
		localparam logic [1:0]  POS_E = 2'(k % WORD_COUNT);
		localparam logic [1:0]  POS_D = 2'(WORD_COUNT - 1 - (k % WORD_COUNT));
		localparam logic [1:0]  KEY_E = POS_E ^ SUM_E[3:2];
		localparam logic [1:0]  KEY_D = POS_D ^ SUM_D[3:2];

		logic [1:0]  pos;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] sum;
		logic [31:0] kw;
		logic [31:0] mix;
		logic [31:0] upd;
		stage_t      nxt;

		if (k > 0) begin : g_link
			assign stage_in[k] = pipe_s[k-1];
		end

		// Update one word: y is the next word, z the previous one
		always_comb begin
			if (stage_in[k].action == ACTION_DECRYPT) begin
				pos = POS_D;
				sum = SUM_D;
				kw  = key_q[KEY_D];
			end else begin
				pos = POS_E;
				sum = SUM_E;
				kw  = key_q[KEY_E];
			end
			y   = stage_in[k].word[pos + 2'd1];
			z   = stage_in[k].word[pos + 2'd3];
			mix = mix_term(z, y, sum, kw);
			upd = (stage_in[k].action == ACTION_DECRYPT) ?
				stage_in[k].word[pos] - mix : stage_in[k].word[pos] + mix;
			nxt = stage_in[k];
			nxt.word[pos] = upd;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_s[k] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				if (k == 0) begin
					vld_s[k] <= blk_valid;
				end else begin
					vld_s[k] <= vld_s[k > 0 ? k - 1 : 0];
				end
			end
		end
	end

	// Output register: load a finished block, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && vld_s[LAST]) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[LAST]) begin
			res_q.result_word_0 <= pipe_s[LAST].word[0];
			res_q.result_word_1 <= pipe_s[LAST].word[1];
			res_q.result_word_2 <= pipe_s[LAST].word[2];
			res_q.result_word_3 <= pipe_s[LAST].word[3];
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// A blocked result with a block waiting behind it holds the request side
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready && vld_s[LAST]) |-> !blk_ready)
		else $error("request taken while the last stage is blocked");

	// An accepted request lands in the first stage
	a_first_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(blk_valid && blk_ready) |=> vld_s[0])
		else $error("accepted request missing from the first stage");

	// A held pipe keeps its last stage
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (vld_s[LAST] && $stable(pipe_s[LAST])))
		else $error("last stage changed while the pipe was held");

	// A finished block moves into the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s[LAST]) |=> res_valid_q)
		else $error("finished block did not reach the output register");

endmodule

`default_nettype wire
